FILE: design/tbm_pkg.sv
`default_nettype none

package tbm_pkg;

    // Field widths of the item and result beats.
    localparam int COORD_W     = 12;
    localparam int TOL_W       = 8;
    localparam int PCT_W       = 8;
    localparam int COUNT_OUT_W = 7;

    // Shared multiplier: a 24-bit operand by a 12-bit operand.
    localparam int AREA_W  = 2 * COORD_W;
    localparam int MUL_A_W = AREA_W;
    localparam int MUL_B_W = COORD_W;
    localparam int PROD_W  = 32;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int MAX_OBJECTS_DEFAULT = 64;

    localparam logic [MUL_B_W-1:0] PCT_SCALE = MUL_B_W'(100);

    localparam logic [COORD_W-1:0] MIN_SIDE_RST  = COORD_W'(25);
    localparam logic [COORD_W-1:0] MAX_SIDE_RST  = COORD_W'(600);
    localparam logic [TOL_W-1:0]   POS_TOL_RST   = TOL_W'(20);
    localparam logic [PCT_W-1:0]   AREA_LOW_RST  = PCT_W'(80);
    localparam logic [PCT_W-1:0]   AREA_HIGH_RST = PCT_W'(120);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } box_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_SIDE  = 3'd0,
        REG_MAX_SIDE  = 3'd1,
        REG_POS_TOL   = 3'd2,
        REG_AREA_LOW  = 3'd3,
        REG_AREA_HIGH = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_QUERY_AREA,
        MUL_STORED_AREA,
        MUL_LOW,
        MUL_HIGH,
        MUL_SCALE
    } mul_op_t;

    typedef struct packed {
        logic [COORD_W-1:0] query_w;
        logic [COORD_W-1:0] query_h;
        logic [COORD_W-1:0] stored_w;
        logic [COORD_W-1:0] stored_h;
        logic [AREA_W-1:0]  area;
        logic [PCT_W-1:0]   low;
        logic [PCT_W-1:0]   high;
    } mul_opnd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QAREA,
        ST_QSCALE,
        ST_READ,
        ST_SAREA,
        ST_LOW,
        ST_HIGH,
        ST_MSCALE,
        ST_DONE
    } tbm_state_t;

endpackage

`default_nettype wire

FILE: design/tracked_box_match_table.sv
// Load beat: the accepted item passes through the LOAD and DONE states to the registered result.
// Query beat: QAREA and QSCALE, then READ, SAREA, LOW and HIGH for each stored box, plus
// MSCALE for each matching entry, then DONE; one shared multiplier sets the pace.
// One item is in flight at a time; item_stall is high from acceptance until the result
// is placed in the output register, so a new item is taken only once the last is through.
// Reset (rst_n low, asynchronous) empties the table and restores the defaults.
`default_nettype none

module tracked_box_match_table #(
    parameter  int MAX_OBJECTS = tbm_pkg::MAX_OBJECTS_DEFAULT,
    localparam int CNT_W       = $clog2(MAX_OBJECTS + 1),
    localparam int ADDR_W      = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Item channel.
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                func,
    input  wire logic                                list_start,
    input  wire logic [tbm_pkg::COORD_W-1:0]         rect_x,
    input  wire logic [tbm_pkg::COORD_W-1:0]         rect_y,
    input  wire logic [tbm_pkg::COORD_W-1:0]         rect_width,
    input  wire logic [tbm_pkg::COORD_W-1:0]         rect_height,

    // Result channel.
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     accepted,
    output logic                                     matched,
    output logic [tbm_pkg::COORD_W-1:0]              out_x,
    output logic [tbm_pkg::COORD_W-1:0]              out_y,
    output logic [tbm_pkg::COORD_W-1:0]              out_width,
    output logic [tbm_pkg::COORD_W-1:0]              out_height,
    output logic [tbm_pkg::COUNT_OUT_W-1:0]          stored_count,

    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tbm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tbm_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user must issue
    // them only while the block is idle; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] min_side_reg;
    logic [COORD_W-1:0] max_side_reg;
    logic [TOL_W-1:0]   pos_tol_reg;
    logic [PCT_W-1:0]   area_low_reg;
    logic [PCT_W-1:0]   area_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_side_reg  <= MIN_SIDE_RST;
            max_side_reg  <= MAX_SIDE_RST;
            pos_tol_reg   <= POS_TOL_RST;
            area_low_reg  <= AREA_LOW_RST;
            area_high_reg <= AREA_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_SIDE:  min_side_reg  <= cfg_data[COORD_W-1:0];
                REG_MAX_SIDE:  max_side_reg  <= cfg_data[COORD_W-1:0];
                REG_POS_TOL:   pos_tol_reg   <= cfg_data[TOL_W-1:0];
                REG_AREA_LOW:  area_low_reg  <= cfg_data[PCT_W-1:0];
                REG_AREA_HIGH: area_high_reg <= cfg_data[PCT_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers.
    // ------------------------------------------------------------------
    tbm_state_t state_reg, state_next;

    logic               func_reg,      func_next;
    logic               start_reg,     start_next;
    box_t               cur_reg,       cur_next;       // current query box
    logic               hit_any_reg,   hit_any_next;   // any entry matched so far
    logic               acc_reg,       acc_next;       // load was stored
    logic [CNT_W-1:0]   count_reg,     count_next;     // boxes in the table
    logic [CNT_W-1:0]   idx_reg,       idx_next;       // entry under test
    logic [AREA_W-1:0]  area_reg,      area_next;      // query area, then stored area
    logic [PROD_W-1:0]  qa100_reg,     qa100_next;     // 100 times the current box area
    logic [PROD_W-1:0]  low_prod_reg,  low_prod_next;  // low percent times stored area

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic               accepted_reg;
    logic               matched_reg;
    box_t               out_box_reg;
    logic [COUNT_OUT_W-1:0] stored_count_reg;

    // Memory and multiplier hookup.
    logic               mem_wr_en;
    logic               mem_rd_en;
    box_t               rd_box;
    mul_op_t            mul_op;
    mul_opnd_t          mul_opnd;
    logic [PROD_W-1:0]  product;

    // ------------------------------------------------------------------
    // Load decision. With list_start the table is considered empty before
    // the new box; a box that passes the size filter into a full table is
    // refused.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] load_base;
    logic             size_ok;
    logic             store_ok;

    assign load_base = start_reg ? '0 : count_reg;
    assign size_ok   = (cur_reg.w > min_side_reg) && (cur_reg.h > min_side_reg) &&
                       (cur_reg.w < max_side_reg) && (cur_reg.h < max_side_reg);
    assign store_ok  = size_ok && (load_base < MAX_CNT);

    // ------------------------------------------------------------------
    // Match test for the entry under test. The area window is checked in
    // exact integers: low * stored <= 100 * query <= high * stored. The
    // high product comes straight off the multiplier in the HIGH step.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               tol_ok;
    logic               area_ok;
    logic               hit;
    logic [CNT_W-1:0]   idx_inc;
    logic               last_entry;

    assign dx      = (cur_reg.x >= rd_box.x) ? (cur_reg.x - rd_box.x) : (rd_box.x - cur_reg.x);
    assign dy      = (cur_reg.y >= rd_box.y) ? (cur_reg.y - rd_box.y) : (rd_box.y - cur_reg.y);
    assign tol_ok  = (dx <= {{(COORD_W-TOL_W){1'b0}}, pos_tol_reg}) &&
                     (dy <= {{(COORD_W-TOL_W){1'b0}}, pos_tol_reg});
    assign area_ok = (low_prod_reg <= qa100_reg) && (qa100_reg <= product);
    assign hit     = area_ok && tol_ok;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign last_entry = (idx_inc >= count_reg);

    // The result register frees up this cycle if it is empty or being taken.
    logic out_free;
    assign out_free = !out_valid_reg || !result_stall;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = func ? ST_QAREA : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_DONE;
            ST_QAREA:  state_next = ST_QSCALE;
            ST_QSCALE: state_next = (count_reg != '0) ? ST_READ : ST_DONE;
            ST_READ:   state_next = ST_SAREA;
            ST_SAREA:  state_next = ST_LOW;
            ST_LOW:    state_next = ST_HIGH;
            ST_HIGH:
            begin
                if (hit)
                begin
                    state_next = ST_MSCALE;
                end
                else
                begin
                    state_next = last_entry ? ST_DONE : ST_READ;
                end
            end
            ST_MSCALE: state_next = last_entry ? ST_DONE : ST_READ;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, memory strobes and multiplier op.
    // ------------------------------------------------------------------
    always_comb
    begin
        item_stall = 1'b1;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;
        mul_op     = MUL_QUERY_AREA;
        unique case (state_reg)
            ST_IDLE:   item_stall = 1'b0;
            ST_LOAD:   mem_wr_en  = store_ok;
            ST_QAREA:  mul_op     = MUL_QUERY_AREA;
            ST_QSCALE: mul_op     = MUL_SCALE;
            ST_READ:   mem_rd_en  = 1'b1;
            ST_SAREA:  mul_op     = MUL_STORED_AREA;
            ST_LOW:    mul_op     = MUL_LOW;
            ST_HIGH:   mul_op     = MUL_HIGH;
            ST_MSCALE: mul_op     = MUL_SCALE;
            ST_DONE:   ;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------
    always_comb
    begin
        func_next     = func_reg;
        start_next    = start_reg;
        cur_next      = cur_reg;
        hit_any_next  = hit_any_reg;
        acc_next      = acc_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        area_next     = area_reg;
        qa100_next    = qa100_reg;
        low_prod_next = low_prod_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    func_next    = func;
                    start_next   = list_start;
                    cur_next     = '{x: rect_x, y: rect_y, w: rect_width, h: rect_height};
                    hit_any_next = 1'b0;
                    acc_next     = 1'b0;
                end
            end
            ST_LOAD:
            begin
                acc_next   = store_ok;
                count_next = store_ok ? (load_base + CNT_W'(1)) : load_base;
            end
            ST_QAREA:
            begin
                area_next = product[AREA_W-1:0];
            end
            ST_QSCALE:
            begin
                qa100_next = product;
                idx_next   = '0;
            end
            ST_SAREA:
            begin
                area_next = product[AREA_W-1:0];
            end
            ST_LOW:
            begin
                low_prod_next = product;
            end
            ST_HIGH:
            begin
                // On a match the stored box replaces the query box and the
                // walk continues against it; its area is rescaled next.
                if (hit)
                begin
                    cur_next     = rd_box;
                    hit_any_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_MSCALE:
            begin
                qa100_next = product;
                idx_next   = idx_inc;
            end
            ST_READ, ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            func_reg    <= 1'b0;
            start_reg   <= 1'b0;
            hit_any_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            func_reg    <= func_next;
            start_reg   <= start_next;
            hit_any_reg <= hit_any_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        area_reg     <= area_next;
        qa100_reg    <= qa100_next;
        low_prod_reg <= low_prod_next;
    end

    // ------------------------------------------------------------------
    // Result register. A load reports only accepted and the count; a query
    // reports the final box, the match flag and the count.
    // ------------------------------------------------------------------
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            accepted_reg     <= !func_reg && acc_reg;
            matched_reg      <= func_reg && hit_any_reg;
            out_box_reg      <= func_reg ? cur_reg : '0;
            stored_count_reg <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign result_valid = out_valid_reg;
    assign accepted     = accepted_reg;
    assign matched      = matched_reg;
    assign out_x        = out_box_reg.x;
    assign out_y        = out_box_reg.y;
    assign out_width    = out_box_reg.w;
    assign out_height   = out_box_reg.h;
    assign stored_count = stored_count_reg;

    // ------------------------------------------------------------------
    // Box table and shared multiplier.
    // ------------------------------------------------------------------
    tbm_box_mem #(
        .DEPTH (MAX_OBJECTS)
    ) u_box_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (load_base[ADDR_W-1:0]),
        .wr_data (cur_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_box)
    );

    assign mul_opnd = '{
        query_w:  cur_reg.w,
        query_h:  cur_reg.h,
        stored_w: rd_box.w,
        stored_h: rd_box.h,
        area:     area_reg,
        low:      area_low_reg,
        high:     area_high_reg
    };

    tbm_arith u_arith (
        .op      (mul_op),
        .opnd    (mul_opnd),
        .product (product)
    );

endmodule

`default_nettype wire

FILE: design/tbm_box_mem.sv
`default_nettype none

module tbm_box_mem #(
    parameter  int DEPTH  = tbm_pkg::MAX_OBJECTS_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire tbm_pkg::box_t     wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output tbm_pkg::box_t          rd_data
);
    import tbm_pkg::*;

    box_t mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/tbm_arith.sv
`default_nettype none

module tbm_arith (
    input  wire tbm_pkg::mul_op_t            op,
    input  wire tbm_pkg::mul_opnd_t          opnd,
    output logic [tbm_pkg::PROD_W-1:0]       product
);
    import tbm_pkg::*;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_full;

    // Operand selection for the single shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            MUL_QUERY_AREA:
            begin
                mul_a = {{(MUL_A_W-COORD_W){1'b0}}, opnd.query_w};
                mul_b = opnd.query_h;
            end
            MUL_STORED_AREA:
            begin
                mul_a = {{(MUL_A_W-COORD_W){1'b0}}, opnd.stored_w};
                mul_b = opnd.stored_h;
            end
            MUL_LOW:
            begin
                mul_a = opnd.area;
                mul_b = {{(MUL_B_W-PCT_W){1'b0}}, opnd.low};
            end
            MUL_HIGH:
            begin
                mul_a = opnd.area;
                mul_b = {{(MUL_B_W-PCT_W){1'b0}}, opnd.high};
            end
            MUL_SCALE:
            begin
                mul_a = opnd.area;
                mul_b = PCT_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Every product used here stays below 2^32 (area times at most 255).
    assign product = mul_full[PROD_W-1:0];

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
    import tbm_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     TABLE_DEPTH  = MAX_OBJECTS_DEFAULT;
    localparam longint LIMIT_CYCLES = 3000000;

    // Operation codes carried on the func field.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic func;
        logic list_start;
        box_t box;
    } box_item_t;

    typedef struct packed {
        logic                   accepted;
        logic                   matched;
        box_t                   box;
        logic [COUNT_OUT_W-1:0] count;
    } box_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   item_valid  = 1'b0;
    logic                   item_stall;
    logic                   func        = FUNC_LOAD;
    logic                   list_start  = 1'b0;
    logic [COORD_W-1:0]     rect_x      = '0;
    logic [COORD_W-1:0]     rect_y      = '0;
    logic [COORD_W-1:0]     rect_width  = '0;
    logic [COORD_W-1:0]     rect_height = '0;

    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   accepted;
    logic                   matched;
    logic [COORD_W-1:0]     out_x;
    logic [COORD_W-1:0]     out_y;
    logic [COORD_W-1:0]     out_width;
    logic [COORD_W-1:0]     out_height;
    logic [COUNT_OUT_W-1:0] stored_count;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    tracked_box_match_table #(
        .MAX_OBJECTS (TABLE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .list_start   (list_start),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .accepted     (accepted),
        .matched      (matched),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_width    (out_width),
        .out_height   (out_height),
        .stored_count (stored_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The run is cut off here if the block ever hangs.
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the box table, its fill level and
    // the five configuration registers, starting from the reset values.
    // ------------------------------------------------------------------
    box_t               table_boxes [TABLE_DEPTH];
    int unsigned        table_fill  = 0;
    logic [COORD_W-1:0] min_side_q  = MIN_SIDE_RST;
    logic [COORD_W-1:0] max_side_q  = MAX_SIDE_RST;
    logic [TOL_W-1:0]   pos_tol_q   = POS_TOL_RST;
    logic [PCT_W-1:0]   area_low_q  = AREA_LOW_RST;
    logic [PCT_W-1:0]   area_high_q = AREA_HIGH_RST;

    // Statistics for the closing summary.
    int load_beats   = 0;
    int stored_boxes = 0;
    int full_refused = 0;
    int query_beats  = 0;
    int query_hits   = 0;
    int error_count  = 0;

    box_item_t   pending_items [$];
    box_result_t box_results_due [$];
    box_t        loaded_boxes [$];
    box_item_t   held_item;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic near_enough(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        logic [COORD_W-1:0] diff;
        diff = (a >= b) ? a - b : b - a;
        return diff <= pos_tol_q;
    endfunction

    // Applies one item beat to the table copy and returns the result the
    // block must produce for it. A load filters on size and appends unless
    // the table is full; a query walks every stored entry in order, and each
    // match replaces the box that later entries are compared against.
    function automatic box_result_t match_or_store_box(box_item_t it);
        box_result_t     res;
        box_t            cur;
        box_t            sb;
        logic            size_ok;
        longint unsigned stored_area;
        longint unsigned query_area100;

        res = '0;
        if (it.func == FUNC_LOAD)
        begin
            load_beats++;
            if (it.list_start)
                table_fill = 0;
            size_ok = (it.box.w > min_side_q) && (it.box.h > min_side_q) &&
                      (it.box.w < max_side_q) && (it.box.h < max_side_q);
            if (size_ok && table_fill < TABLE_DEPTH)
            begin
                table_boxes[table_fill] = it.box;
                table_fill++;
                res.accepted = 1'b1;
                stored_boxes++;
            end
            else if (size_ok)
                full_refused++;
        end
        else
        begin
            // list_start has no effect on a query.
            query_beats++;
            cur = it.box;
            for (int j = 0; j < table_fill; j++)
            begin
                sb = table_boxes[j];
                stored_area   = sb.w * sb.h;
                query_area100 = cur.w * cur.h * 100;
                if ((area_low_q * stored_area <= query_area100) &&
                    (query_area100 <= area_high_q * stored_area) &&
                    near_enough(cur.x, sb.x) && near_enough(cur.y, sb.y))
                begin
                    cur         = sb;
                    res.matched = 1'b1;
                end
            end
            res.box = cur;
            if (res.matched)
                query_hits++;
        end
        res.count = table_fill[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item driver. The prediction is made at the edge where the beat is
    // taken, so the table copy follows the block's own order of items.
    // A beat that is stalled stays on the port untouched.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                box_results_due.push_back(match_or_store_box(held_item));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    held_item   = pending_items.pop_front();
                    item_valid  <= 1'b1;
                    func        <= held_item.func;
                    list_start  <= held_item.list_start;
                    rect_x      <= held_item.box.x;
                    rect_y      <= held_item.box.y;
                    rect_width  <= held_item.box.w;
                    rect_height <= held_item.box.h;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: every beat taken is compared with the oldest
    // prediction. The stall is redrawn each cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        box_result_t exp;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (box_results_due.size() == 0)
                begin
                    $error("result beat arrived with no prediction waiting");
                    error_count++;
                end
                else
                begin
                    exp = box_results_due.pop_front();
                    check_field("accepted", exp.accepted, accepted);
                    check_field("matched", exp.matched, matched);
                    check_field("out_x", exp.box.x, out_x);
                    check_field("out_y", exp.box.y, out_y);
                    check_field("out_width", exp.box.w, out_width);
                    check_field("out_height", exp.box.h, out_height);
                    check_field("stored_count", exp.count, stored_count);
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    function automatic void queue_item(logic f, logic s, logic [COORD_W-1:0] x,
                                       logic [COORD_W-1:0] y, logic [COORD_W-1:0] w,
                                       logic [COORD_W-1:0] h);
        box_item_t it;
        it.func       = f;
        it.list_start = s;
        it.box        = '{x: x, y: y, w: w, h: h};
        pending_items.push_back(it);
        // Remember loaded boxes so that queries can aim at them.
        if (f == FUNC_LOAD)
        begin
            if (s)
                loaded_boxes.delete();
            loaded_boxes.push_back(it.box);
        end
    endfunction

    // A value within spread of base, wrapping at the field width.
    function automatic logic [COORD_W-1:0] jitter(logic [COORD_W-1:0] base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        return v[COORD_W-1:0];
    endfunction

    // A side that passes the current size filter, if any side can.
    function automatic logic [COORD_W-1:0] pick_side();
        int lo;
        int hi;
        lo = int'(min_side_q) + 1;
        hi = int'(max_side_q) - 1;
        if (hi >= lo)
            return COORD_W'($urandom_range(lo, hi));
        return COORD_W'($urandom());
    endfunction

    // One well-formed burst: a list of loads clustered around one spot,
    // mostly opened with list_start, followed by queries aimed at the
    // loaded boxes with position and size pushed around the limits.
    // Now and then the list is long enough to overflow the table.
    function automatic int queue_box_list();
        int                 n;
        int                 m;
        int                 tol;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        box_t               pick;

        tol = int'(pos_tol_q);
        n   = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
        bx  = COORD_W'($urandom());
        by  = COORD_W'($urandom());
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                w = COORD_W'($urandom());
                h = COORD_W'($urandom());
            end
            else
            begin
                w = pick_side();
                h = pick_side();
            end
            queue_item(FUNC_LOAD, (i == 0) && ($urandom_range(7) != 0),
                       jitter(bx, tol + 1), jitter(by, tol + 1), w, h);
        end
        m = $urandom_range(1, 6);
        for (int i = 0; i < m; i++)
        begin
            pick = loaded_boxes[$urandom_range(loaded_boxes.size() - 1)];
            if ($urandom_range(1) == 0)
            begin
                w = pick.w;
                h = pick.h;
            end
            else
            begin
                w = jitter(pick.w, pick.w / 5 + 1);
                h = jitter(pick.h, pick.h / 5 + 1);
            end
            queue_item(FUNC_QUERY, 1'($urandom_range(1)),
                       jitter(pick.x, tol + 2), jitter(pick.y, tol + 2), w, h);
        end
        return n + m;
    endfunction

    // Mostly well-formed bursts; about one draw in ten is a single beat of pure noise.
    function automatic void queue_random_items(int total);
        int made;
        made = 0;
        while (made < total)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_item(1'($urandom()), 1'($urandom()), COORD_W'($urandom()),
                           COORD_W'($urandom()), COORD_W'($urandom()),
                           COORD_W'($urandom()));
                made++;
            end
            else
                made += queue_box_list();
        end
    endfunction

    // Wait until every beat is sent and every prediction has been met,
    // then give the block a little time to settle before touching
    // its registers.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_items.size() > 0 || box_results_due.size() > 0 || item_valid);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write; the predictor picks up the new value once the
    // beat has been taken.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_SIDE:  min_side_q  = value[COORD_W-1:0];
            REG_MAX_SIDE:  max_side_q  = value[COORD_W-1:0];
            REG_POS_TOL:   pos_tol_q   = value[TOL_W-1:0];
            REG_AREA_LOW:  area_low_q  = value[PCT_W-1:0];
            REG_AREA_HIGH: area_high_q = value[PCT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [COORD_W-1:0] min_s, logic [COORD_W-1:0] max_s,
                              logic [TOL_W-1:0] tol, logic [PCT_W-1:0] lo_pct,
                              logic [PCT_W-1:0] hi_pct);
        write_reg(REG_MIN_SIDE, min_s);
        write_reg(REG_MAX_SIDE, max_s);
        write_reg(REG_POS_TOL, CFG_DATA_W'(tol));
        write_reg(REG_AREA_LOW, CFG_DATA_W'(lo_pct));
        write_reg(REG_AREA_HIGH, CFG_DATA_W'(hi_pct));
    endtask

    task automatic run_phase(int sender_idle, int receiver_stall, int items);
        @(negedge clk);
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        queue_random_items(items);
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // Test sequence. The first two phases run with a rarely idle sender
    // and a mostly stalling receiver, the next two the other way round,
    // and the last two with no idling at all.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset limits: sides 25 and 600 are the
        // rejecting edges, tolerance 20, area window 80 to 120 percent.
        @(negedge clk);
        send_idle_pct  = 16;
        recv_stall_pct = 86;
        queue_item(FUNC_LOAD, 1'b1, 12'd100, 12'd100, 12'd26, 12'd26);
        queue_item(FUNC_LOAD, 1'b0, 12'd0, 12'd0, 12'd25, 12'd100);
        queue_item(FUNC_LOAD, 1'b0, 12'd0, 12'd0, 12'd100, 12'd25);
        queue_item(FUNC_LOAD, 1'b0, 12'd0, 12'd0, 12'd600, 12'd100);
        queue_item(FUNC_LOAD, 1'b0, 12'd0, 12'd0, 12'd100, 12'd600);
        queue_item(FUNC_LOAD, 1'b0, 12'd4095, 12'd4095, 12'd599, 12'd599);
        queue_item(FUNC_LOAD, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        queue_item(FUNC_LOAD, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        // A query with list_start set must leave the table alone.
        queue_item(FUNC_QUERY, 1'b1, 12'd100, 12'd100, 12'd26, 12'd26);
        queue_item(FUNC_QUERY, 1'b0, 12'd120, 12'd80, 12'd26, 12'd26);
        queue_item(FUNC_QUERY, 1'b0, 12'd121, 12'd100, 12'd26, 12'd26);
        // Area edges against a 100 by 100 stored box.
        queue_item(FUNC_LOAD, 1'b1, 12'd1000, 12'd1000, 12'd100, 12'd100);
        queue_item(FUNC_QUERY, 1'b0, 12'd1000, 12'd1000, 12'd80, 12'd100);
        queue_item(FUNC_QUERY, 1'b0, 12'd1000, 12'd1000, 12'd79, 12'd100);
        queue_item(FUNC_QUERY, 1'b0, 12'd1000, 12'd1000, 12'd120, 12'd100);
        queue_item(FUNC_QUERY, 1'b0, 12'd1000, 12'd1000, 12'd121, 12'd100);
        // Two entries in a row match, so the walk hands the first match on.
        queue_item(FUNC_LOAD, 1'b0, 12'd1010, 12'd1010, 12'd110, 12'd110);
        queue_item(FUNC_QUERY, 1'b0, 12'd1005, 12'd1005, 12'd105, 12'd105);
        queue_item(FUNC_QUERY, 1'b0, 12'd4095, 12'd0, 12'd4095, 12'd4095);
        queue_item(FUNC_QUERY, 1'b0, 12'd0, 12'd4095, 12'd0, 12'd0);
        // An empty table returns the query box untouched.
        queue_item(FUNC_LOAD, 1'b1, 12'd5, 12'd5, 12'd1, 12'd1);
        queue_item(FUNC_QUERY, 1'b0, 12'd5, 12'd5, 12'd30, 12'd30);
        wait_quiet();

        run_phase(16, 86, 270);

        // Widest window: sides from 1 to 4094 pass, area from 0 to 255 percent.
        set_limits(12'd0, 12'd4095, 8'd255, 8'd0, 8'd255);
        run_phase(16, 86, 270);

        // Inverted limits: nothing is stored and nothing matches.
        set_limits(12'd4095, 12'd0, 8'd0, 8'd255, 8'd0);
        run_phase(86, 16, 270);

        // Exact area only, tight position window.
        set_limits(12'd10, 12'd300, 8'd3, 8'd100, 8'd100);
        run_phase(86, 16, 270);

        set_limits(12'd50, 12'd2000, 8'd60, 8'd50, 8'd200);
        run_phase(0, 0, 270);

        set_limits(MIN_SIDE_RST, MAX_SIDE_RST, POS_TOL_RST, AREA_LOW_RST, AREA_HIGH_RST);
        run_phase(0, 0, 270);

        $display("Covered %0d loads (%0d stored, %0d refused by a full table) and %0d queries",
                 load_beats, stored_boxes, full_refused, query_beats);
        $display("(%0d matched) across six register settings and three idling patterns.",
                 query_hits);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
